FILE: hdl/hes_pkg.sv
// Package with the types, constants and register map of the haptic effect sequencer.
package hes_pkg;

   localparam int QUEUE_DEPTH = 32;
   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_PLAYBACK_TIMEOUT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STANDBY_RETRY = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STOP_EFFECT = 2'd2;

   localparam logic [15:0] PLAYBACK_TIMEOUT_RESET = 16'd1000;
   localparam logic [15:0] STANDBY_RETRY_RESET = 16'd100;
   localparam logic [7:0] STOP_EFFECT_RESET = 8'd118;

   localparam logic KIND_ENQUEUE = 1'b0;
   localparam logic KIND_SERVICE = 1'b1;

   typedef enum logic [1:0] {
      MODE_STANDBY = 2'd0,
      MODE_PLAYING = 2'd1,
      MODE_AWAIT = 2'd2
   } mode_type;

   typedef struct packed {
      logic [2:0] pad;
      logic standby_ok;
      logic stop_ok;
      logic play_ok;
      logic wake_ok;
      logic driver_done;
      logic [31:0] now_ms;
      logic [7:0] effect_id;
   } req_fields_type;

   typedef struct packed {
      logic [1:0] pad;
      logic [7:0] playing_effect;
      logic [5:0] pending_count;
      logic dropped;
      logic error_flag;
      logic issued_standby;
      logic issued_stop;
      logic issued_wake;
      logic [7:0] started_effect;
      logic started_valid;
      logic [1:0] mode_now;
   } rsp_fields_type;

   typedef struct packed {
      logic started;
      logic [7:0] started_effect;
      logic wake;
      logic stop;
      logic standby;
      logic error;
      logic dropped;
   } step_events_type;

endpackage

FILE: hdl/haptic_effect_sequencer_unit.sv
// Haptic effect sequencer: effect queue, playback state machine and result register.
// A request is held in the input register, then its result goes to the result register.
// Throughput: one item per cycle if no result stalls, by one pass of state update logic.
// A result that waits on rsp_tready holds the input register and so stalls req_tready.
// Synchronous active-high reset sets standby, clears pointers, counts, times and the
// active effect, and loads the default settings.
module haptic_effect_sequencer_unit import hes_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // effect_id, now_ms, driver_done, wake_ok, play_ok, stop_ok, standby_ok, zero pad
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // kind
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // mode_now, started_valid, started_effect, issued_wake, issued_stop,
   // issued_standby, error_flag, dropped, pending_count, playing_effect, zero pad
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [15:0] timeout_ff;
   logic [15:0] retry_ff;
   logic [7:0] stop_id_ff;

   logic in_valid_ff;
   logic in_kind_ff;
   req_fields_type in_data_ff;

   logic rsp_valid_ff;
   rsp_fields_type rsp_data_ff;
   rsp_fields_type rsp_data_in;

   logic [7:0] fifo_mem [QUEUE_DEPTH];

   mode_type mode_ff, mode_in;
   logic [PTR_W-1:0] rptr_ff, rptr_in;
   logic [PTR_W-1:0] wptr_ff, wptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [31:0] play_start_ff, play_start_in;
   logic [31:0] last_try_ff, last_try_in;
   logic [7:0] active_ff, active_in;
   logic fail_rep_ff, fail_rep_in;

   step_events_type events;
   logic advance;
   logic fifo_write;
   logic [7:0] head_ff;
   logic [PTR_W-1:0] head_addr;
   logic [31:0] play_elapsed;
   logic [31:0] retry_elapsed;

   assign advance = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   assign head_addr = advance ? rptr_in : rptr_ff;
   assign play_elapsed = in_data_ff.now_ms - play_start_ff;
   assign retry_elapsed = in_data_ff.now_ms - last_try_ff;
   assign fifo_write = advance && (in_kind_ff == KIND_ENQUEUE)
                       && (fill_ff < FILL_W'(QUEUE_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= PLAYBACK_TIMEOUT_RESET;
         retry_ff <= STANDBY_RETRY_RESET;
         stop_id_ff <= STOP_EFFECT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PLAYBACK_TIMEOUT: timeout_ff <= csr_wdata;
            CSR_STANDBY_RETRY: retry_ff <= csr_wdata;
            CSR_STOP_EFFECT: stop_id_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_kind_ff <= req_tuser;
         in_data_ff <= req_tdata;
      end
   end

   // The head register follows the next read pointer and forwards a write to that entry.
   always_ff @(posedge clock) begin
      if (fifo_write) begin
         fifo_mem[wptr_ff] <= in_data_ff.effect_id;
      end
      if (fifo_write && wptr_ff == head_addr) begin
         head_ff <= in_data_ff.effect_id;
      end else begin
         head_ff <= fifo_mem[head_addr];
      end
   end

   // Next state: enqueue, or the three service phases in order, as one pass.
   always_comb begin
      logic entered_await;
      logic launch_fail;
      mode_in = mode_ff;
      rptr_in = rptr_ff;
      wptr_in = wptr_ff;
      fill_in = fill_ff;
      play_start_in = play_start_ff;
      last_try_in = last_try_ff;
      active_in = active_ff;
      fail_rep_in = fail_rep_ff;
      events = '0;
      entered_await = 1'b0;
      launch_fail = 1'b0;
      if (in_kind_ff == KIND_ENQUEUE) begin
         if (fill_ff >= FILL_W'(QUEUE_DEPTH)) begin
            events.dropped = 1'b1;
            events.error = 1'b1;
         end else begin
            wptr_in = (wptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
            fill_in = fill_ff + 1'b1;
         end
      end else begin
         if (mode_ff == MODE_PLAYING) begin
            if (in_data_ff.driver_done) begin
               active_in = '0;
               if (fill_ff != '0 && in_data_ff.play_ok) begin
                  rptr_in = (rptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
                  fill_in = fill_ff - 1'b1;
                  play_start_in = in_data_ff.now_ms;
                  active_in = head_ff;
                  fail_rep_in = 1'b0;
                  events.started = 1'b1;
                  events.started_effect = head_ff;
               end else begin
                  if (fill_ff != '0) begin
                     events.error = 1'b1;
                  end
                  mode_in = MODE_AWAIT;
                  entered_await = 1'b1;
               end
            end else if (play_elapsed >= {16'd0, timeout_ff}) begin
               if (active_ff != stop_id_ff || !in_data_ff.stop_ok) begin
                  events.error = 1'b1;
               end
               events.stop = 1'b1;
               active_in = '0;
               mode_in = MODE_AWAIT;
               entered_await = 1'b1;
            end
         end
         if (mode_in == MODE_AWAIT
             && (entered_await || retry_elapsed >= {16'd0, retry_ff})) begin
            last_try_in = in_data_ff.now_ms;
            events.standby = 1'b1;
            if (in_data_ff.standby_ok) begin
               mode_in = MODE_STANDBY;
               fail_rep_in = 1'b0;
            end else if (!fail_rep_ff) begin
               fail_rep_in = 1'b1;
               events.error = 1'b1;
            end
         end
         if (mode_in != MODE_PLAYING && mode_in != MODE_AWAIT && fill_in != '0) begin
            events.wake = 1'b1;
            launch_fail = !in_data_ff.wake_ok || !in_data_ff.play_ok;
            if (launch_fail) begin
               events.error = 1'b1;
               active_in = '0;
               mode_in = MODE_AWAIT;
               last_try_in = in_data_ff.now_ms - {16'd0, retry_ff};
            end else begin
               rptr_in = (rptr_in == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_in + 1'b1;
               fill_in = fill_in - 1'b1;
               play_start_in = in_data_ff.now_ms;
               active_in = head_ff;
               fail_rep_in = 1'b0;
               mode_in = MODE_PLAYING;
               events.started = 1'b1;
               events.started_effect = head_ff;
            end
         end
         if (entered_await && !events.standby) begin
            last_try_in = in_data_ff.now_ms - {16'd0, retry_ff};
         end
      end
   end

   always_comb begin
      rsp_data_in = '0;
      rsp_data_in.mode_now = mode_in;
      rsp_data_in.started_valid = events.started;
      rsp_data_in.started_effect = events.started_effect;
      rsp_data_in.issued_wake = events.wake;
      rsp_data_in.issued_stop = events.stop;
      rsp_data_in.issued_standby = events.standby;
      rsp_data_in.error_flag = events.error;
      rsp_data_in.dropped = events.dropped;
      rsp_data_in.pending_count = 6'(fill_in);
      rsp_data_in.playing_effect = active_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_STANDBY;
         rptr_ff <= '0;
         wptr_ff <= '0;
         fill_ff <= '0;
         play_start_ff <= '0;
         last_try_ff <= '0;
         active_ff <= '0;
         fail_rep_ff <= 1'b0;
      end else if (advance) begin
         mode_ff <= mode_in;
         rptr_ff <= rptr_in;
         wptr_ff <= wptr_in;
         fill_ff <= fill_in;
         play_start_ff <= play_start_in;
         last_try_ff <= last_try_in;
         active_ff <= active_in;
         fail_rep_ff <= fail_rep_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(QUEUE_DEPTH))
      else $error("Queue fill count exceeds its depth.");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0 || fill_ff == FILL_W'(QUEUE_DEPTH)) |-> wptr_ff == rptr_ff)
      else $error("Queue pointers disagree with an empty or full fill count.");

   a_idle_no_effect: assert property (@(posedge clock) disable iff (reset)
      mode_ff != MODE_PLAYING |-> active_ff == '0)
      else $error("An active effect is held outside the playing state.");

   a_start_plays: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.started_valid)
         |-> rsp_data_ff.mode_now == MODE_PLAYING)
      else $error("A started effect was reported without entering playback.");

   a_drop_error: assert property (@(posedge clock) disable iff (reset)
      advance && events.dropped |=> rsp_data_ff.error_flag && rsp_data_ff.pending_count
         == 6'(QUEUE_DEPTH))
      else $error("A dropped effect was not reported as an error on a full queue.");

endmodule
